### rtl/core/crcpf_pkg.sv
// Shared types, codes and the CRC byte update for the CRC-16 packet framer.
package crcpf_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SYNC_FIRST_RESET = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RESET = 8'h55;

  localparam logic CFG_SYNC_FIRST = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_PAYLOAD = 1'b1;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_TOO_LONG     = 2'd1,
    ST_NOT_OPEN     = 2'd2,
    ST_ALREADY_OPEN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    STEP_FIRST,
    STEP_SYNC2,
    STEP_TYPE,
    STEP_LEN,
    STEP_CRC_LO,
    STEP_CRC_HI
  } step_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] packet_type;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
    logic       last;
  } out_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/crcpf_out_reg.sv
// Output register holding one framed result until it is taken.
module crcpf_out_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  crcpf_pkg::out_t push_data_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output crcpf_pkg::out_t out_data_o
);

  logic            vld_q, vld_d;
  crcpf_pkg::out_t data_q;

  assign free_o = !vld_q || out_ready_i;
  assign vld_d  = push_i || (vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q <= push_data_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

### rtl/core/crcpf_seq.sv
// Input holding register and framing sequencer with running CRC and packet state.
module crcpf_seq #(
  parameter int unsigned MaxPayload = crcpf_pkg::MAX_PAYLOAD
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [7:0]      sync_first_i,
  input  logic [7:0]      sync_second_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  crcpf_pkg::in_t  in_data_i,
  input  logic            free_i,
  output logic            push_o,
  output crcpf_pkg::out_t push_data_o
);

  localparam logic [7:0] MaxLen = 8'(MaxPayload);

  crcpf_pkg::in_t   item_q;
  logic             item_vld_q, item_vld_d;
  crcpf_pkg::step_e step_q, step_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       left_q, left_d;
  logic             open_q, open_d;

  crcpf_pkg::out_t  res;
  logic             adv;
  logic             take;
  logic [7:0]       left_dec;
  logic             too_long;

  assign adv      = item_vld_q && free_i;
  assign in_ready_o = !item_vld_q || (adv && res.last);
  assign take     = in_valid_i && in_ready_o;
  assign left_dec = left_q - 8'd1;
  assign too_long = item_q.payload_length > MaxLen;

  always_comb begin
    res = '{out_byte: 8'h00, status: crcpf_pkg::ST_OK, last: 1'b0};
    unique case (step_q)
      crcpf_pkg::STEP_FIRST: begin
        if (item_q.req_type == crcpf_pkg::REQ_HEADER) begin
          if (open_q) begin
            res.status = crcpf_pkg::ST_ALREADY_OPEN;
            res.last   = 1'b1;
          end else if (too_long) begin
            res.status = crcpf_pkg::ST_TOO_LONG;
            res.last   = 1'b1;
          end else begin
            res.out_byte = sync_first_i;
          end
        end else begin
          if (!open_q) begin
            res.status = crcpf_pkg::ST_NOT_OPEN;
            res.last   = 1'b1;
          end else begin
            res.out_byte = item_q.data_byte;
            res.last     = (left_dec != 8'd0);
          end
        end
      end
      crcpf_pkg::STEP_SYNC2:  res.out_byte = sync_second_i;
      crcpf_pkg::STEP_TYPE:   res.out_byte = item_q.packet_type;
      crcpf_pkg::STEP_LEN: begin
        res.out_byte = item_q.payload_length;
        res.last     = (item_q.payload_length != 8'd0);
      end
      crcpf_pkg::STEP_CRC_LO: res.out_byte = crc_q[7:0];
      crcpf_pkg::STEP_CRC_HI: begin
        res.out_byte = crc_q[15:8];
        res.last     = 1'b1;
      end
      default: res = '{out_byte: 8'h00, status: crcpf_pkg::ST_OK, last: 1'b1};
    endcase
  end

  always_comb begin
    step_d     = step_q;
    crc_d      = crc_q;
    left_d     = left_q;
    open_d     = open_q;
    item_vld_d = item_vld_q;
    if (adv) begin
      unique case (step_q)
        crcpf_pkg::STEP_FIRST: begin
          if (res.status == crcpf_pkg::ST_OK) begin
            if (item_q.req_type == crcpf_pkg::REQ_HEADER) begin
              crc_d  = crcpf_pkg::crc_feed(crcpf_pkg::CRC_INIT, res.out_byte);
              step_d = crcpf_pkg::STEP_SYNC2;
            end else begin
              crc_d  = crcpf_pkg::crc_feed(crc_q, res.out_byte);
              left_d = left_dec;
              if (left_dec == 8'd0) begin
                step_d = crcpf_pkg::STEP_CRC_LO;
              end
            end
          end
        end
        crcpf_pkg::STEP_SYNC2: begin
          crc_d  = crcpf_pkg::crc_feed(crc_q, res.out_byte);
          step_d = crcpf_pkg::STEP_TYPE;
        end
        crcpf_pkg::STEP_TYPE: begin
          crc_d  = crcpf_pkg::crc_feed(crc_q, res.out_byte);
          step_d = crcpf_pkg::STEP_LEN;
        end
        crcpf_pkg::STEP_LEN: begin
          crc_d = crcpf_pkg::crc_feed(crc_q, res.out_byte);
          if (item_q.payload_length == 8'd0) begin
            step_d = crcpf_pkg::STEP_CRC_LO;
          end else begin
            left_d = item_q.payload_length;
            open_d = 1'b1;
            step_d = crcpf_pkg::STEP_FIRST;
          end
        end
        crcpf_pkg::STEP_CRC_LO: step_d = crcpf_pkg::STEP_CRC_HI;
        crcpf_pkg::STEP_CRC_HI: begin
          crc_d  = crcpf_pkg::CRC_INIT;
          left_d = 8'd0;
          open_d = 1'b0;
          step_d = crcpf_pkg::STEP_FIRST;
        end
        default: step_d = crcpf_pkg::STEP_FIRST;
      endcase
      if (res.last) begin
        item_vld_d = 1'b0;
      end
    end
    if (take) begin
      item_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      step_q     <= crcpf_pkg::STEP_FIRST;
      crc_q      <= crcpf_pkg::CRC_INIT;
      left_q     <= 8'd0;
      open_q     <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      step_q     <= step_d;
      crc_q      <= crc_d;
      left_q     <= left_d;
      open_q     <= open_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

  assign push_o      = adv;
  assign push_data_o = res;

endmodule

### rtl/core/crc16_packet_framer.sv
// Top level of the CRC-16 packet framer: sync registers, sequencer and output register.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_ready_o   in_data_i  (crcpf_pkg::in_t)
//   out      output     out_valid_o/out_ready_i out_data_o (crcpf_pkg::out_t)
//   cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// One result leaves per cycle while the output register is free; an item gives one result
// for a payload byte or an error, three for the last payload byte, four or six
// for a header. The sequencer steps and the single output register set this rate.
// Reset clears the packet state, loads the CRC with 0xFFFF and the sync bytes with
// 0xAA and 0x55. A stalled output holds its result while the next item waits.
module crc16_packet_framer #(
  parameter int unsigned MaxPayload = crcpf_pkg::MAX_PAYLOAD
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  crcpf_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output crcpf_pkg::out_t out_data_o
);

  logic [7:0]      sync_first_q;
  logic [7:0]      sync_second_q;
  logic            free;
  logic            push;
  crcpf_pkg::out_t push_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= crcpf_pkg::SYNC_FIRST_RESET;
      sync_second_q <= crcpf_pkg::SYNC_SECOND_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crcpf_pkg::CFG_SYNC_FIRST:  sync_first_q  <= cfg_data_i;
        crcpf_pkg::CFG_SYNC_SECOND: sync_second_q <= cfg_data_i;
        default: sync_first_q <= sync_first_q;
      endcase
    end
  end

  crcpf_seq #(
    .MaxPayload(MaxPayload)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sync_first_i (sync_first_q),
    .sync_second_i(sync_second_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .free_i       (free),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  crcpf_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .free_o     (free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### tb/sv/crcpf_tb_pkg.sv
// Scoreboard for the CRC-16 packet framer: expected-frame predictor and result checker.
package crcpf_tb_pkg;

  class framer_scoreboard;
    logic [7:0]      sync_a;
    logic [7:0]      sync_b;
    logic [15:0]     crc_acc;
    logic [7:0]      remaining;
    bit              pkt_open;
    crcpf_pkg::out_t frames_due[$];
    int unsigned     errors;

    function new();
      sync_a    = crcpf_pkg::SYNC_FIRST_RESET;
      sync_b    = crcpf_pkg::SYNC_SECOND_RESET;
      crc_acc   = crcpf_pkg::CRC_INIT;
      remaining = '0;
      pkt_open  = 1'b0;
      errors    = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] value);
      if (idx == crcpf_pkg::CFG_SYNC_FIRST) begin
        sync_a = value;
      end else begin
        sync_b = value;
      end
    endfunction

    function logic [15:0] crc_next(logic [15:0] acc, logic [7:0] b);
      logic [15:0] r;
      r = acc ^ {b, 8'h00};
      repeat (8) begin
        r = r[15] ? ({r[14:0], 1'b0} ^ crcpf_pkg::CRC_POLY) : {r[14:0], 1'b0};
      end
      return r;
    endfunction

    function void frame_byte(logic [7:0] b);
      crc_acc = crc_next(crc_acc, b);
      frames_due.push_back('{b, crcpf_pkg::ST_OK, 1'b0});
    endfunction

    function void close_packet();
      frames_due.push_back('{crc_acc[7:0], crcpf_pkg::ST_OK, 1'b0});
      frames_due.push_back('{crc_acc[15:8], crcpf_pkg::ST_OK, 1'b0});
      crc_acc   = crcpf_pkg::CRC_INIT;
      remaining = '0;
      pkt_open  = 1'b0;
    endfunction

    function void note_input(crcpf_pkg::in_t item);
      crcpf_pkg::status_e fault;
      fault = crcpf_pkg::ST_OK;
      if (item.req_type == crcpf_pkg::REQ_HEADER) begin
        if (pkt_open) begin
          fault = crcpf_pkg::ST_ALREADY_OPEN;
        end else if (item.payload_length > crcpf_pkg::MAX_PAYLOAD) begin
          fault = crcpf_pkg::ST_TOO_LONG;
        end else begin
          crc_acc = crcpf_pkg::CRC_INIT;
          frame_byte(sync_a);
          frame_byte(sync_b);
          frame_byte(item.packet_type);
          frame_byte(item.payload_length);
          if (item.payload_length == 8'd0) begin
            close_packet();
          end else begin
            remaining = item.payload_length;
            pkt_open  = 1'b1;
          end
        end
      end else if (!pkt_open) begin
        fault = crcpf_pkg::ST_NOT_OPEN;
      end else begin
        frame_byte(item.data_byte);
        remaining = remaining - 8'd1;
        if (remaining == 8'd0) begin
          close_packet();
        end
      end
      if (fault != crcpf_pkg::ST_OK) begin
        frames_due.push_back('{8'h00, fault, 1'b1});
      end else begin
        frames_due[frames_due.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(crcpf_pkg::out_t got, time stamp);
      crcpf_pkg::out_t want;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: out_byte %02h status %0d last %0b",
                 stamp, got.out_byte, got.status, got.last);
        return;
      end
      want = frames_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %02h actual %02h",
                 stamp, want.out_byte, got.out_byte);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d actual %0d",
                 stamp, want.status, got.status);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch: expected %0b actual %0b",
                 stamp, want.last, got.last);
      end
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction
  endclass

endpackage

### tb/sv/crc16_packet_framer_tb.sv
// Top-level testbench for the CRC-16 packet framer: clock, reset, stimulus and checking.
module crc16_packet_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_ITEMS   = 20;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SLOW} rx_mode_e;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic            cfg_idx   = crcpf_pkg::CFG_SYNC_FIRST;
  logic [7:0]      cfg_data  = 8'h00;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  crcpf_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  crcpf_pkg::out_t out_data;

  bit          hold_off     = 1'b0;
  int unsigned burst_left   = 1;
  int unsigned items_sent   = 0;
  int unsigned quiet_cycles = 0;

  crcpf_tb_pkg::framer_scoreboard sb = new();

  always #5 clk = ~clk;

  crc16_packet_framer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sb.note_input(in_data);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_data, $time);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("crc16_packet_framer_tb: done, errors");
      $finish;
    end
  end

  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    mode      = RX_OPEN;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 64);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
          default:   out_ready <= ($urandom_range(0, 5) == 0);
        endcase
      end
    end
  end

  function automatic crcpf_pkg::in_t header_req(logic [7:0] ptype, logic [7:0] len);
    crcpf_pkg::in_t r;
    r.req_type       = crcpf_pkg::REQ_HEADER;
    r.packet_type    = ptype;
    r.payload_length = len;
    r.data_byte      = 8'($urandom);
    return r;
  endfunction

  function automatic crcpf_pkg::in_t payload_req(logic [7:0] b);
    crcpf_pkg::in_t r;
    r.req_type       = crcpf_pkg::REQ_PAYLOAD;
    r.packet_type    = 8'($urandom);
    r.payload_length = 8'($urandom);
    r.data_byte      = b;
    return r;
  endfunction

  function automatic logic [7:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'd0;
    if (r < 80) return 8'($urandom_range(1, 8));
    if (r < 95) return 8'($urandom_range(9, crcpf_pkg::MAX_PAYLOAD - 1));
    return 8'(crcpf_pkg::MAX_PAYLOAD);
  endfunction

  task automatic send_item(input crcpf_pkg::in_t item);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
    burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
    end
  endtask

  task automatic send_packet(input logic [7:0] len);
    send_item(header_req(8'($urandom), len));
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        send_item(header_req(8'($urandom), 8'($urandom)));
      end
      send_item(payload_req(8'($urandom)));
    end
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 0) begin
      send_item(payload_req(8'($urandom)));
    end else begin
      send_item(header_req(8'($urandom),
                           8'($urandom_range(crcpf_pkg::MAX_PAYLOAD + 1, 255))));
    end
  endtask

  task automatic random_phase(input int unsigned n);
    int unsigned stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        send_packet(pick_length());
      end else begin
        send_noise();
      end
    end
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_sync(input logic [7:0] first_byte, input logic [7:0] second_byte);
    cfg_we   <= 1'b1;
    cfg_idx  <= crcpf_pkg::CFG_SYNC_FIRST;
    cfg_data <= first_byte;
    sb.write_reg(crcpf_pkg::CFG_SYNC_FIRST, first_byte);
    @(negedge clk);
    cfg_idx  <= crcpf_pkg::CFG_SYNC_SECOND;
    cfg_data <= second_byte;
    sb.write_reg(crcpf_pkg::CFG_SYNC_SECOND, second_byte);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(payload_req(8'hFF));
    send_item(payload_req(8'h00));
    send_item(header_req(8'h00, 8'd0));
    send_item(header_req(8'hFF, 8'd0));
    send_item(header_req(8'hFF, 8'(crcpf_pkg::MAX_PAYLOAD + 1)));
    send_item(header_req(8'h80, 8'd255));
    send_item(header_req(8'h5A, 8'd3));
    send_item(payload_req(8'h00));
    send_item(header_req(8'h11, 8'd0));
    send_item(header_req(8'h22, 8'd200));
    send_item(payload_req(8'hFF));
    send_item(payload_req(8'h80));
    send_item(header_req(8'h01, 8'd1));
    send_item(payload_req(8'hA5));
    send_item(header_req(8'hC3, 8'd2));
    send_item(payload_req(8'h7F));
    send_item(payload_req(8'h01));
    drain();

    set_sync(8'h00, 8'hFF);
    random_phase(PHASE_ITEMS);
    drain();

    @(posedge clk);
    hold_off = 1'b1;
    @(negedge clk);
    set_sync(8'hFF, 8'h00);
    random_phase(PHASE_ITEMS);
    drain();

    set_sync(8'($urandom), 8'($urandom));
    send_packet(8'(crcpf_pkg::MAX_PAYLOAD));
    random_phase(PHASE_ITEMS);
    drain();

    if (sb.errors == 0) begin
      $display("crc16_packet_framer_tb: done, clean");
    end else begin
      $display("crc16_packet_framer_tb: done, errors");
    end
    $finish;
  end

endmodule
